// ----- sv/gscw_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and control structs of the grid segment cell walk.
package gscw_pkg;

  localparam int MAX_CELLS_PER_AXIS = 32;
  localparam int AXIS_BITS = $clog2(MAX_CELLS_PER_AXIS);
  localparam int MAX_OUT = 63;

  localparam int COORD_W = 16;   // input coordinates and origins
  localparam int SIZE_W = 12;    // cell width and height
  localparam int COUNT_W = 6;    // columns_used, rows_used, result count
  localparam int INDEX_W = 10;   // cell_index
  localparam int REL_W = COORD_W + 1;       // coordinate minus origin
  localparam int CELL_W = COORD_W + 2;      // signed cell coordinate
  localparam int DIV_W = COORD_W;           // magnitude of a relative coordinate
  localparam int ITER_W = $clog2(DIV_W);
  localparam int MUL_W = SIZE_W + COORD_W;  // boundary distance times delta
  localparam int PROD_W = MUL_W + 6;        // running scaled distances

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_USED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED    = 3'd5;

  // divider operand select
  localparam logic [1:0] OP_X0 = 2'd0;
  localparam logic [1:0] OP_Y0 = 2'd1;
  localparam logic [1:0] OP_X1 = 2'd2;
  localparam logic [1:0] OP_Y1 = 2'd3;

  // multiplier job select
  localparam logic [1:0] MUL_P  = 2'd0;
  localparam logic [1:0] MUL_Q  = 2'd1;
  localparam logic [1:0] MUL_WA = 2'd2;
  localparam logic [1:0] MUL_HB = 2'd3;

  localparam logic [1:0] SEL_LAST = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [SIZE_W-1:0]         cell_width;
    logic [SIZE_W-1:0]         cell_height;
    logic [COUNT_W-1:0]        columns_used;
    logic [COUNT_W-1:0]        rows_used;
  } gscw_cfg_t;

  typedef struct packed {
    logic       idle;
    logic       load;
    logic       div_load;
    logic       div_iter;
    logic       div_store;
    logic       mul;
    logic       walk;
    logic       flush;
    logic [1:0] sel;
  } gscw_cmd_t;

  typedef struct packed {
    logic walk_hold;
    logic at_end;
    logic out_free;
  } gscw_stat_t;

endpackage

// ----- sv/gscw_seg_if.sv -----
`timescale 1ns / 1ps
// Segment input channel.
interface gscw_seg_if import gscw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ----- sv/gscw_cell_if.sv -----
`timescale 1ns / 1ps
// Cell result output channel.
interface gscw_cell_if import gscw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] cell_index;
  logic               inside_res;
  logic               last;

  modport source (output valid, cell_index, inside_res, last, input ready);
  modport sink (input valid, cell_index, inside_res, last, output ready);
endinterface

// ----- sv/gscw_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration register write channel.
interface gscw_cfg_if import gscw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/gscw_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: load, four divisions, four multiplies, walk, final flush.
module gscw_ctrl import gscw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  gscw_stat_t stat,
  output gscw_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DLOAD  = 3'd1;
  localparam logic [2:0] S_DITER  = 3'd2;
  localparam logic [2:0] S_DSTORE = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_W - 1);

  logic [2:0]        state, state_next;
  logic [1:0]        sel, sel_next;
  logic [ITER_W-1:0] iter, iter_next;

  always_comb begin
    state_next = state;
    sel_next = sel;
    iter_next = iter;
    cmd = '0;
    cmd.sel = sel;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          sel_next = OP_X0;
          state_next = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        iter_next = '0;
        state_next = S_DITER;
      end
      S_DITER: begin
        cmd.div_iter = 1'b1;
        iter_next = iter + 1'b1;
        if (iter == ITER_LAST) state_next = S_DSTORE;
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        sel_next = sel + 1'b1;
        if (sel == SEL_LAST) state_next = S_MUL;
        else state_next = S_DLOAD;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        sel_next = sel + 1'b1;
        if (sel == SEL_LAST) state_next = S_WALK;
      end
      S_WALK: begin
        cmd.walk = !stat.walk_hold;
        if (cmd.walk && stat.at_end) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel <= '0;
      iter <= '0;
    end else begin
      state <= state_next;
      sel <= sel_next;
      iter <= iter_next;
    end
  end

endmodule

// ----- sv/gscw_dp.sv -----
`timescale 1ns / 1ps
// Datapath: floor divider, setup multiplier, walk registers and output word.
module gscw_dp import gscw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  gscw_cfg_t                 cfg,
  input  gscw_cmd_t                 cmd,
  output gscw_stat_t                stat,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [INDEX_W-1:0]        cell_index,
  output logic                      inside_res,
  output logic                      last
);

  localparam logic [COUNT_W-1:0] AXIS_MAX = COUNT_W'(MAX_CELLS_PER_AXIS);
  localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(MAX_OUT);

  // segment, latched at load
  logic signed [REL_W-1:0] rx0, ry0, rx1, ry1;
  logic [SIZE_W-1:0]       w, h;
  logic [COUNT_W-1:0]      cols, rows;
  logic [DIV_W-1:0]        adx, ady;
  logic                    dx_pos, dx_neg, dy_pos, dy_neg;

  // divider
  logic [SIZE_W-1:0] div_rem, div_d;
  logic [DIV_W-1:0]  div_quo;
  logic              div_neg;

  // walk
  logic signed [CELL_W-1:0] x, y, lx, ly;
  logic [SIZE_W-1:0]        rem_x0, rem_y0;
  logic [PROD_W-1:0]        p_acc, q_acc;
  logic [MUL_W-1:0]         wa, hb;
  logic                     pend_v;
  logic [INDEX_W-1:0]       pend_idx;
  logic [COUNT_W-1:0]       cnt;

  // load-time arithmetic
  logic signed [REL_W-1:0] rx0_n, ry0_n, rx1_n, ry1_n, dx_n, dy_n;
  logic [REL_W-1:0]        adx_n, ady_n;

  assign rx0_n = {start_x[COORD_W-1], start_x} - {cfg.origin_x[COORD_W-1], cfg.origin_x};
  assign ry0_n = {start_y[COORD_W-1], start_y} - {cfg.origin_y[COORD_W-1], cfg.origin_y};
  assign rx1_n = {end_x[COORD_W-1], end_x} - {cfg.origin_x[COORD_W-1], cfg.origin_x};
  assign ry1_n = {end_y[COORD_W-1], end_y} - {cfg.origin_y[COORD_W-1], cfg.origin_y};
  assign dx_n = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
  assign dy_n = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
  assign adx_n = dx_n[REL_W-1] ? REL_W'(-dx_n) : REL_W'(dx_n);
  assign ady_n = dy_n[REL_W-1] ? REL_W'(-dy_n) : REL_W'(dy_n);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx0 <= rx0_n;
      ry0 <= ry0_n;
      rx1 <= rx1_n;
      ry1 <= ry1_n;
      adx <= adx_n[DIV_W-1:0];
      ady <= ady_n[DIV_W-1:0];
      dx_pos <= !dx_n[REL_W-1] && (dx_n != '0);
      dx_neg <= dx_n[REL_W-1];
      dy_pos <= !dy_n[REL_W-1] && (dy_n != '0);
      dy_neg <= dy_n[REL_W-1];
      // zero size behaves as one
      w <= (cfg.cell_width == '0) ? SIZE_W'(1) : cfg.cell_width;
      h <= (cfg.cell_height == '0) ? SIZE_W'(1) : cfg.cell_height;
      cols <= (cfg.columns_used > AXIS_MAX) ? AXIS_MAX : cfg.columns_used;
      rows <= (cfg.rows_used > AXIS_MAX) ? AXIS_MAX : cfg.rows_used;
    end
  end

  // restoring divider on magnitudes, floor fix-up at store
  logic signed [REL_W-1:0] div_a;
  logic [REL_W-1:0]        div_mag;
  logic [SIZE_W:0]         trial;
  logic signed [CELL_W-1:0] q_ext, fq;
  logic [SIZE_W-1:0]        fr;

  always_comb begin
    case (cmd.sel)
      OP_X0:   div_a = rx0;
      OP_Y0:   div_a = ry0;
      OP_X1:   div_a = rx1;
      default: div_a = ry1;
    endcase
  end

  assign div_mag = div_a[REL_W-1] ? REL_W'(-div_a) : REL_W'(div_a);
  assign trial = {div_rem, div_quo[DIV_W-1]} - {1'b0, div_d};
  assign q_ext = $signed(CELL_W'(div_quo));
  assign fq = div_neg ? ((div_rem != '0) ? -q_ext - CELL_W'(1) : -q_ext) : q_ext;
  assign fr = (div_neg && div_rem != '0) ? div_d - div_rem : div_rem;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_quo <= div_mag[DIV_W-1:0];
      div_rem <= '0;
      div_neg <= div_a[REL_W-1];
      div_d <= cmd.sel[0] ? h : w;
    end else if (cmd.div_iter) begin
      if (!trial[SIZE_W]) begin
        div_rem <= trial[SIZE_W-1:0];
        div_quo <= {div_quo[DIV_W-2:0], 1'b1};
      end else begin
        div_rem <= {div_rem[SIZE_W-2:0], div_quo[DIV_W-1]};
        div_quo <= {div_quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  // first boundary distances from the floor remainders
  logic [SIZE_W-1:0] nx0, ny0, mul_a;
  logic [DIV_W-1:0]  mul_b;
  logic [MUL_W-1:0]  prod;

  assign nx0 = dx_pos ? w - rem_x0 : (dx_neg ? rem_x0 : '0);
  assign ny0 = dy_pos ? h - rem_y0 : (dy_neg ? rem_y0 : '0);

  always_comb begin
    case (cmd.sel)
      MUL_P:   begin mul_a = nx0; mul_b = ady; end
      MUL_Q:   begin mul_a = ny0; mul_b = adx; end
      MUL_WA:  begin mul_a = w;   mul_b = ady; end
      default: begin mul_a = h;   mul_b = adx; end
    endcase
  end

  assign prod = MUL_W'(mul_a) * MUL_W'(mul_b);

  // walk step
  logic              in_grid, at_end, emit_new, out_free, hold, take_x;
  logic [INDEX_W-1:0] idx;

  assign in_grid = !x[CELL_W-1] && (x < $signed(CELL_W'(cols))) &&
                   !y[CELL_W-1] && (y < $signed(CELL_W'(rows)));
  assign at_end = (x == lx) && (y == ly);
  assign emit_new = in_grid && (cnt != CNT_MAX);
  assign out_free = !out_valid || out_ready;
  assign hold = emit_new && pend_v && !out_free;
  // row axis wins a tie
  assign take_x = (y == ly) ? 1'b1 : ((x == lx) ? 1'b0 : (p_acc < q_acc));
  assign idx = INDEX_W'(INDEX_W'(x[AXIS_BITS-1:0]) * INDEX_W'(rows)) +
               INDEX_W'(y[AXIS_BITS-1:0]);

  assign stat.walk_hold = hold;
  assign stat.at_end = at_end;
  assign stat.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.sel)
        OP_X0:   begin x <= fq; rem_x0 <= fr; end
        OP_Y0:   begin y <= fq; rem_y0 <= fr; end
        OP_X1:   lx <= fq;
        default: ly <= fq;
      endcase
    end
    if (cmd.mul) begin
      case (cmd.sel)
        MUL_P:   p_acc <= PROD_W'(prod);
        MUL_Q:   q_acc <= PROD_W'(prod);
        MUL_WA:  wa <= prod;
        default: hb <= prod;
      endcase
    end
    if (cmd.walk && !at_end) begin
      if (take_x) begin
        x <= (x < lx) ? x + CELL_W'(1) : x - CELL_W'(1);
        p_acc <= p_acc + PROD_W'(wa);
      end else begin
        y <= (y < ly) ? y + CELL_W'(1) : y - CELL_W'(1);
        q_acc <= q_acc + PROD_W'(hb);
      end
    end
    if (cmd.walk && emit_new) pend_idx <= idx;
  end

  // one cell held back so the final word can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        pend_v <= 1'b0;
        cnt <= '0;
      end
      if (cmd.walk && emit_new) begin
        pend_v <= 1'b1;
        cnt <= cnt + 1'b1;
        if (pend_v) out_valid <= 1'b1;
      end
      if (cmd.flush) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk && emit_new && pend_v) begin
      cell_index <= pend_idx;
      inside_res <= 1'b1;
      last <= 1'b0;
    end else if (cmd.flush) begin
      cell_index <= pend_v ? pend_idx : '0;
      inside_res <= pend_v;
      last <= 1'b1;
    end
  end

  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.flush && !pend_v |=> out_valid && !inside_res && last)
    else $error("empty segment word wrong");

  a_pend_counted: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> cnt != '0)
    else $error("held cell not counted");

  a_push_word: assert property (@(posedge clk) disable iff (rst)
    cmd.walk && emit_new && pend_v |=> out_valid && inside_res && !last)
    else $error("pushed cell word wrong");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !pend_v && cnt == '0)
    else $error("segment load left walk state");

endmodule

// ----- sv/grid_segment_cell_walk.sv -----
`timescale 1ns / 1ps
// Top level: configuration registers, sequencer and datapath of the cell walk.
//
// A segment word (start_x, start_y, end_x, end_y) enters on seg; the block
// answers on cells with the linear index column*rows+row of each grid cell the
// segment crosses, in walk order, last set on the final word of the segment.
// A segment with no cell inside the grid gives one word with inside_res clear.
// At most 63 cells are reported; the walk still runs to the end cell.
// Registers are written on cfg (index, data); write them only while idle.
// Work per segment: a load, four floor divisions on a shared one-bit-per-cycle
// divider, four products on one shared multiplier, then one walk step per cell
// visited (|end column - start column| + |end row - start row| + 1), held while
// cells stalls, then the final word.
// seg.ready is high only while no segment is in work. One result is held
// back until the next is found, so the first word appears after the second
// inside cell or at the end of the walk. When cells stalls, the output
// register holds its word and the walk waits at the next reportable cell.
// Reset (rst, synchronous) empties the block and loads register defaults:
// origin 0, cell size 16 by 16, 32 columns and 32 rows.
module grid_segment_cell_walk import gscw_pkg::*; (
  input logic         clk,
  input logic         rst,
  gscw_seg_if.sink    seg,
  gscw_cell_if.source cells,
  gscw_cfg_if.sink    cfg
);

  gscw_cfg_t  regs;
  gscw_cmd_t  cmd;
  gscw_stat_t stat;

  assign cfg.ready = 1'b1;
  assign seg.ready = cmd.idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_x <= '0;
      regs.origin_y <= '0;
      regs.cell_width <= SIZE_W'(16);
      regs.cell_height <= SIZE_W'(16);
      regs.columns_used <= COUNT_W'(32);
      regs.rows_used <= COUNT_W'(32);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ORIGIN_X:     regs.origin_x <= $signed(cfg.data[COORD_W-1:0]);
        REG_ORIGIN_Y:     regs.origin_y <= $signed(cfg.data[COORD_W-1:0]);
        REG_CELL_WIDTH:   regs.cell_width <= cfg.data[SIZE_W-1:0];
        REG_CELL_HEIGHT:  regs.cell_height <= cfg.data[SIZE_W-1:0];
        REG_COLUMNS_USED: regs.columns_used <= cfg.data[COUNT_W-1:0];
        REG_ROWS_USED:    regs.rows_used <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  gscw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (seg.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  gscw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .cmd        (cmd),
    .stat       (stat),
    .start_x    (seg.start_x),
    .start_y    (seg.start_y),
    .end_x      (seg.end_x),
    .end_y      (seg.end_y),
    .out_valid  (cells.valid),
    .out_ready  (cells.ready),
    .cell_index (cells.cell_index),
    .inside_res (cells.inside_res),
    .last       (cells.last)
  );

endmodule

// ----- verif/cell_walk_checker.sv -----
`timescale 1ns / 1ps
// Watches the cell walk channels, predicts the cell words of each segment and compares them.
module cell_walk_checker import gscw_pkg::*; (
  input  logic clk,
  input  logic rst,
  gscw_seg_if  seg,
  gscw_cell_if cells,
  gscw_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [INDEX_W-1:0] cell_index;
    logic               inside_res;
    logic               last;
  } cell_word_t;

  cell_word_t cells_due[$];

  logic signed [COORD_W-1:0] org_x;
  logic signed [COORD_W-1:0] org_y;
  logic [SIZE_W-1:0]         size_w;
  logic [SIZE_W-1:0]         size_h;
  logic [COUNT_W-1:0]        n_cols;
  logic [COUNT_W-1:0]        n_rows;

  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // Walk the segment cell by cell and queue the words it must produce.
  function automatic void predict_walk(input logic signed [COORD_W-1:0] sx,
                                       input logic signed [COORD_W-1:0] sy,
                                       input logic signed [COORD_W-1:0] ex,
                                       input logic signed [COORD_W-1:0] ey);
    longint w, h, cols, rows, rx0, ry0, rx1, ry1;
    longint x, y, lx, ly, dx, dy, adx, ady, nx, ny;
    int found;
    logic step_x, done;
    cell_word_t held;
    w = (size_w == 0) ? 1 : longint'(size_w);
    h = (size_h == 0) ? 1 : longint'(size_h);
    cols = (n_cols > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : longint'(n_cols);
    rows = (n_rows > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : longint'(n_rows);
    rx0 = longint'(sx) - longint'(org_x);
    ry0 = longint'(sy) - longint'(org_y);
    rx1 = longint'(ex) - longint'(org_x);
    ry1 = longint'(ey) - longint'(org_y);
    x = floor_div(rx0, w);
    y = floor_div(ry0, h);
    lx = floor_div(rx1, w);
    ly = floor_div(ry1, h);
    dx = rx1 - rx0;
    dy = ry1 - ry0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    nx = 0;
    ny = 0;
    if (dx > 0) nx = (x + 1) * w - rx0;
    else if (dx < 0) nx = rx0 - x * w;
    if (dy > 0) ny = (y + 1) * h - ry0;
    else if (dy < 0) ny = ry0 - y * h;
    found = 0;
    done = 1'b0;
    held = '0;
    while (!done) begin
      if (x >= 0 && x < cols && y >= 0 && y < rows && found < MAX_OUT) begin
        if (found > 0) cells_due = {cells_due, held};
        held = '{INDEX_W'(x * rows + y), 1'b1, 1'b0};
        found++;
      end
      if (x == lx && y == ly) begin
        done = 1'b1;
      end else begin
        // distances to the next boundaries, cross-scaled; a tie goes to the row axis
        if (y == ly) step_x = 1'b1;
        else if (x == lx) step_x = 1'b0;
        else step_x = (nx * ady < ny * adx);
        if (step_x) begin
          x += (x < lx) ? 1 : -1;
          nx += w;
        end else begin
          y += (y < ly) ? 1 : -1;
          ny += h;
        end
      end
    end
    if (found == 0) held = '{INDEX_W'(0), 1'b0, 1'b1};
    else held.last = 1'b1;
    cells_due = {cells_due, held};
  endfunction

  always @(posedge clk) begin : watch
    cell_word_t got;
    cell_word_t want;
    if (rst) begin
      org_x <= '0;
      org_y <= '0;
      size_w <= SIZE_W'(16);
      size_h <= SIZE_W'(16);
      n_cols <= COUNT_W'(32);
      n_rows <= COUNT_W'(32);
      cells_due.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cells.valid && cells.ready) begin
        got = '{cells.cell_index, cells.inside_res, cells.last};
        if (cells_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: cell word with none expected: index %0d inside %0b last %0b",
                     $realtime, got.cell_index, got.inside_res, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = cells_due.pop_front();
          if (got.cell_index !== want.cell_index || got.inside_res !== want.inside_res ||
              got.last !== want.last) begin
            if (fail_count < 10)
              $display("%0t: cell word mismatch: expected index %0d inside %0b last %0b, %s %0d %s %0b %s %0b",
                       $realtime, want.cell_index, want.inside_res, want.last,
                       "got index", got.cell_index, "inside", got.inside_res,
                       "last", got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ORIGIN_X:     org_x <= cfg.data;
          REG_ORIGIN_Y:     org_y <= cfg.data;
          REG_CELL_WIDTH:   size_w <= cfg.data[SIZE_W-1:0];
          REG_CELL_HEIGHT:  size_h <= cfg.data[SIZE_W-1:0];
          REG_COLUMNS_USED: n_cols <= cfg.data[COUNT_W-1:0];
          REG_ROWS_USED:    n_rows <= cfg.data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (seg.valid && seg.ready)
        predict_walk(seg.start_x, seg.start_y, seg.end_x, seg.end_y);
      pending <= cells_due.size();
    end
  end

endmodule

// ----- verif/tb_grid_segment_cell_walk.sv -----
`timescale 1ns / 1ps
// Stimulus, handshake pacing and verdict for the grid segment cell walk.
module tb_grid_segment_cell_walk;
  import gscw_pkg::*;

  localparam int QUIET_LIMIT = 50000;

  logic clk;
  logic rst;

  gscw_seg_if  seg_ch();
  gscw_cell_if cell_ch();
  gscw_cfg_if  cfg_ch();

  int fail_count;
  int cells_pending;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles = 0;

  // grid as seen by the stimulus shaping (effective sizes)
  int grid_x0, grid_y0, step_w, step_h, span_cols, span_rows;

  grid_segment_cell_walk dut (
    .clk(clk),
    .rst(rst),
    .seg(seg_ch),
    .cells(cell_ch),
    .cfg(cfg_ch)
  );

  cell_walk_checker chk (
    .clk(clk),
    .rst(rst),
    .seg(seg_ch),
    .cells(cell_ch),
    .cfg(cfg_ch),
    .fail_count(fail_count),
    .pending(cells_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst) cell_ch.ready <= 1'b0;
    else cell_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (seg_ch.valid && seg_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp_coord(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // coordinate in a random cell from two before the grid to two past it
  function automatic int pick_coord(input int org, input int size, input int n, input bit snap);
    int k;
    k = int'($urandom_range(n + 3)) - 2;
    return org + size * k + (snap ? 0 : int'($urandom_range(size - 1)));
  endfunction

  task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
    if ($urandom_range(99) < send_idle_pct) begin
      seg_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    seg_ch.valid <= 1'b1;
    seg_ch.start_x <= COORD_W'(clamp_coord(sx));
    seg_ch.start_y <= COORD_W'(clamp_coord(sy));
    seg_ch.end_x <= COORD_W'(clamp_coord(ex));
    seg_ch.end_y <= COORD_W'(clamp_coord(ey));
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained(input int hold);
    seg_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (hold) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_grid(input int ox, input int oy, input int w, input int h,
                          input int cols, input int rows);
    wait_drained(10);
    put_reg(REG_ORIGIN_X, ox);
    put_reg(REG_ORIGIN_Y, oy);
    put_reg(REG_CELL_WIDTH, w);
    put_reg(REG_CELL_HEIGHT, h);
    put_reg(REG_COLUMNS_USED, cols);
    put_reg(REG_ROWS_USED, rows);
    cfg_ch.valid <= 1'b0;
    grid_x0 = ox;
    grid_y0 = oy;
    step_w = (w == 0) ? 1 : w;
    step_h = (h == 0) ? 1 : h;
    span_cols = (cols == 0) ? 1 : ((cols > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : cols);
    span_rows = (rows == 0) ? 1 : ((rows > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : rows);
  endtask

  task automatic send_random_segment();
    int kind, sx, sy, ex, ey, t, reach;
    kind = $urandom_range(99);
    if (kind >= 95 && step_w >= 16 && step_h >= 16) begin
      // any coordinates; walk stays a few thousand cells at most
      sx = int'($urandom_range(65535)) - 32768;
      sy = int'($urandom_range(65535)) - 32768;
      ex = int'($urandom_range(65535)) - 32768;
      ey = int'($urandom_range(65535)) - 32768;
    end else if (kind >= 80) begin
      // crosses the whole grid along one axis
      if ($urandom_range(1)) begin
        sx = grid_x0 - int'($urandom_range(1, 2 * step_w));
        ex = grid_x0 + span_cols * step_w + int'($urandom_range(2 * step_w));
        sy = pick_coord(grid_y0, step_h, span_rows, 1'b0);
        ey = pick_coord(grid_y0, step_h, span_rows, 1'b0);
      end else begin
        sy = grid_y0 - int'($urandom_range(1, 2 * step_h));
        ey = grid_y0 + span_rows * step_h + int'($urandom_range(2 * step_h));
        sx = pick_coord(grid_x0, step_w, span_cols, 1'b0);
        ex = pick_coord(grid_x0, step_w, span_cols, 1'b0);
      end
      if ($urandom_range(1)) begin
        t = sx; sx = ex; ex = t;
        t = sy; sy = ey; ey = t;
      end
    end else begin
      // short segment near or in the grid, often starting on a boundary
      sx = pick_coord(grid_x0, step_w, span_cols, $urandom_range(3) == 0);
      sy = pick_coord(grid_y0, step_h, span_rows, $urandom_range(3) == 0);
      if (kind < 5) begin
        ex = sx;
        ey = sy;
      end else begin
        reach = (kind < 20) ? 1 : 6;
        ex = sx + int'($urandom_range(2 * reach * step_w)) - reach * step_w;
        ey = sy + int'($urandom_range(2 * reach * step_h)) - reach * step_h;
      end
    end
    send_segment(sx, sy, ex, ey);
  endtask

  task automatic run_phase(input int ox, input int oy, input int w, input int h,
                           input int cols, input int rows, input int n);
    set_grid(ox, oy, w, h, cols, rows);
    repeat (n) send_random_segment();
  endtask

  initial begin
    rst <= 1'b1;
    seg_ch.valid <= 1'b0;
    seg_ch.start_x <= '0;
    seg_ch.start_y <= '0;
    seg_ch.end_x <= '0;
    seg_ch.end_y <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_ORIGIN_X;
    cfg_ch.data <= '0;
    send_idle_pct = 32;
    recv_idle_pct = 59;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, on the reset grid: 32 x 32 cells of 16 x 16 at the origin
    send_segment(5, 5, 5, 5);
    send_segment(0, 0, 511, 511);
    send_segment(0, 0, 32, 32);
    send_segment(32, 32, 0, 0);
    send_segment(48, 20, 48, -20);
    send_segment(20, 48, -20, 48);
    send_segment(-100, -100, -50, -20);
    send_segment(600, 10, 900, 500);
    send_segment(-40, 100, 600, 140);
    send_segment(0, 8, 511, 8);
    send_segment(511, 0, 0, 511);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(100, -32768, 100, 32767);
    send_segment(-32768, 100, 32767, 100);
    send_segment(21845, -21846, -21846, 21845);
    send_segment(-21846, 21845, 21845, -21846);
    send_segment(255, 0, 256, 511);
    send_segment(15, 15, 16, 16);
    send_segment(16, 16, 15, 15);
    send_segment(17, 0, 15, 511);

    run_phase(0, 0, 16, 16, 32, 32, 55);
    run_phase(-32768, 32767, 4095, 4095, 32, 32, 45);

    send_idle_pct = 59;
    recv_idle_pct = 32;
    run_phase(-300, 200, 1, 1, 32, 32, 60);
    // zero sizes count as 1, too many columns count as the maximum
    run_phase(5, -5, 0, 0, 63, 1, 45);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1000, -2000, 100, 3, 1, 32, 45);
    // no columns: every segment answers with a single outside word
    run_phase(-4000, 4000, 7, 9, 0, 17, 25);
    run_phase(32767, -32768, 4095, 1, 32, 32, 30);
    repeat (2)
      run_phase(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                $urandom_range(1, 4095), $urandom_range(1, 4095),
                $urandom_range(1, 32), $urandom_range(1, 32), 30);

    wait_drained(200);
    if (fail_count == 0 && cells_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
